// ===== src/cwag_pkg.sv =====
// Shared constants and types for the card whitelist access guard.
`default_nettype none
package cwag_pkg;
  localparam int ENTRIES   = 64;
  localparam int UID_BYTES = 10;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int ENT_W     = 64 + 16 + 4;

  localparam logic [1:0] FUNC_SCAN  = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_DEL   = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  localparam logic [3:0] ST_DONE      = 4'd0;
  localparam logic [3:0] ST_FULL      = 4'd1;
  localparam logic [3:0] ST_NOT_FOUND = 4'd2;
  localparam logic [3:0] ST_COOLDOWN  = 4'd3;
  localparam logic [3:0] ST_LOCKOUT   = 4'd4;
  localparam logic [3:0] ST_DEBOUNCED = 4'd5;
  localparam logic [3:0] ST_UNLOCKED  = 4'd6;
  localparam logic [3:0] ST_REFUSED   = 4'd7;
  localparam logic [3:0] ST_REJECTED  = 4'd8;
  localparam logic [3:0] ST_REJ_LOCK  = 4'd9;

  localparam logic [2:0] REG_DEBOUNCE = 3'd0;
  localparam logic [2:0] REG_COOLDOWN = 3'd1;
  localparam logic [2:0] REG_FLIMIT   = 3'd2;
  localparam logic [2:0] REG_FWINDOW  = 3'd3;
  localparam logic [2:0] REG_LOCKOUT  = 3'd4;

  typedef struct packed {
    logic [63:0] lo;
    logic [15:0] hi;
    logic [3:0]  len;
  } uid_t;
endpackage
`default_nettype wire

// ===== src/card_whitelist_access_guard_core.sv =====
// Card whitelist access guard: table walk, scan policy and configuration.
//
// One command is taken when start is high and busy is low; its result appears
// for exactly one cycle with out_valid. The whitelist sits in a one-port-read
// synchronous memory and is walked one entry per cycle. Add and clear skip the
// walk. A scan or delete reads entries until it finds a match or reaches the end
// of the table; a scan stops at the match. A delete that matches restarts its
// reads just past the match, and the shift then reads each later entry and
// writes it back one slot lower. The longest command is a matching delete in a
// full table. The receiver cannot stall; busy drops as the result is shown.
// Configuration writes are always taken (cfg_ready stays high).
`default_nettype none
module card_whitelist_access_guard_core
  import cwag_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [63:0] in_uid_low,
  input  wire logic [15:0] in_uid_high,
  input  wire logic [3:0]  in_uid_len,
  input  wire logic [31:0] in_now_time,
  input  wire logic        in_key_ready,
  output logic             out_valid,
  output logic [3:0]       out_status,
  output logic [6:0]       out_entry_count,
  output logic [3:0]       out_failure_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;  // issue reads, compare returns
  localparam logic [2:0] S_SHIFT = 3'd2;  // move entries down after a delete
  localparam logic [2:0] S_FIN   = 3'd3;  // resolve command, show result

  logic [2:0] state_r;

  // Configuration
  logic [31:0] debounce_r, cooldown_r, fwindow_r, lockout_r;
  logic [3:0]  flimit_r;

  // Guard state
  logic [CNT_W-1:0] total_r;
  uid_t             last_r;
  logic [31:0]      last_time_r, cool_end_r, lock_end_r, win_start_r;
  logic [3:0]       rej_r;

  // Command latch
  logic [1:0]  func_r;
  uid_t        uid_r;
  logic [31:0] now_r;
  logic        key_r;

  // Walk control
  logic [CNT_W-1:0] rd_ptr_r;   // next address read
  logic             rd_vld_r;   // read data valid this cycle
  logic [CNT_W-1:0] rd_idx_r;   // address of the data now on rd_data_r
  logic             found_r;

  // Memory
  logic [ENT_W-1:0] mem [ENTRIES];
  logic [ENT_W-1:0] rd_data_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // Normalize the incoming identifier: saturate length, zero unused bytes.
  uid_t        in_norm;
  logic [3:0]  len_sat;
  always_comb begin
    len_sat = (in_uid_len > 4'(UID_BYTES)) ? 4'(UID_BYTES) : in_uid_len;
    in_norm.len = len_sat;
    for (int b = 0; b < 8; b++)
      in_norm.lo[b*8 +: 8] = (4'(b) < len_sat) ? in_uid_low[b*8 +: 8] : 8'h00;
    for (int b = 0; b < 2; b++)
      in_norm.hi[b*8 +: 8] = (4'(b + 8) < len_sat) ? in_uid_high[b*8 +: 8] : 8'h00;
  end

  logic accept;
  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  logic hit;
  assign hit = rd_vld_r && (rd_data_r == uid_r);

  // A delete match restarts the reads just past the match to shift the tail.
  logic restart;
  assign restart = (state_r == S_SRCH) && hit && (func_r == FUNC_DEL);

  // Scan policy terms, valid in S_FIN
  logic [31:0] dt_last, dt_win;
  logic        in_cool, in_lock, debounced, win_restart;
  logic [3:0]  rej_base, rej_inc;
  assign dt_last     = now_r - last_time_r;
  assign dt_win      = now_r - win_start_r;
  assign in_cool     = now_r < cool_end_r;
  assign in_lock     = now_r < lock_end_r;
  assign debounced   = (uid_r == last_r) && (dt_last < debounce_r);
  assign win_restart = dt_win > fwindow_r;
  assign rej_base    = win_restart ? 4'd0 : rej_r;
  assign rej_inc     = rej_base + 4'd1;

  // Resolve the command: status, new table total, new failure count and
  // which of the timers and the last identifier to update.
  logic [3:0]       status_nxt, fails_nxt;
  logic [CNT_W-1:0] total_nxt;
  logic             take_last, grant, lock_start;
  always_comb begin
    status_nxt = ST_DONE;
    total_nxt  = total_r;
    fails_nxt  = rej_r;
    take_last  = 1'b0;
    grant      = 1'b0;
    lock_start = 1'b0;
    case (func_r)
      FUNC_ADD: begin
        if (total_r >= CNT_W'(ENTRIES)) status_nxt = ST_FULL;
        else total_nxt = total_r + CNT_W'(1);
      end
      FUNC_DEL: begin
        if (found_r) total_nxt = total_r - CNT_W'(1);
        else status_nxt = ST_NOT_FOUND;
      end
      FUNC_CLEAR: total_nxt = '0;
      default: begin
        if (in_cool) status_nxt = ST_COOLDOWN;
        else if (in_lock) status_nxt = ST_LOCKOUT;
        else if (debounced) status_nxt = ST_DEBOUNCED;
        else begin
          take_last = 1'b1;
          if (found_r) begin
            if (!key_r) begin
              grant      = 1'b1;
              fails_nxt  = '0;
              status_nxt = ST_UNLOCKED;
            end else status_nxt = ST_REFUSED;
          end else if (rej_inc >= flimit_r) begin
            lock_start = 1'b1;
            fails_nxt  = '0;
            status_nxt = ST_REJ_LOCK;
          end else begin
            fails_nxt  = rej_inc;
            status_nxt = ST_REJECTED;
          end
        end
      end
    endcase
  end

  // Memory port drive
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_ptr_r[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = total_r[IDX_W-1:0];
    wr_data = uid_r;
    if (state_r == S_SRCH || state_r == S_SHIFT)
      rd_en = (rd_ptr_r < total_r);
    if (state_r == S_SHIFT && rd_vld_r) begin
      // write back one slot lower
      wr_en   = 1'b1;
      wr_addr = IDX_W'(rd_idx_r - CNT_W'(1));
      wr_data = rd_data_r;
    end
    if (state_r == S_FIN && func_r == FUNC_ADD && total_r < CNT_W'(ENTRIES)) begin
      wr_en   = 1'b1;
      wr_addr = total_r[IDX_W-1:0];
      wr_data = uid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      debounce_r  <= 32'd3000;
      cooldown_r  <= 32'd30000;
      flimit_r    <= 4'd5;
      fwindow_r   <= 32'd60000;
      lockout_r   <= 32'd300000;
      total_r     <= '0;
      last_r      <= '0;
      last_time_r <= '0;
      cool_end_r  <= '0;
      lock_end_r  <= '0;
      win_start_r <= '0;
      rej_r       <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= (state_r == S_FIN);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DEBOUNCE: debounce_r <= cfg_data;
          REG_COOLDOWN: cooldown_r <= cfg_data;
          REG_FLIMIT:   flimit_r   <= cfg_data[3:0];
          REG_FWINDOW:  fwindow_r  <= cfg_data;
          REG_LOCKOUT:  lockout_r  <= cfg_data;
          default: ;
        endcase
      end
      // Drop the read in flight on a delete match and restart past it.
      rd_vld_r <= rd_en && !restart;
      rd_idx_r <= rd_ptr_r;
      if (restart) rd_ptr_r <= rd_idx_r + CNT_W'(1);
      else if (accept) rd_ptr_r <= '0;
      else if (rd_en) rd_ptr_r <= rd_ptr_r + CNT_W'(1);

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r   <= in_func;
            uid_r    <= in_norm;
            now_r    <= in_now_time;
            key_r    <= in_key_ready;
            found_r  <= 1'b0;
            // add and clear need no walk
            state_r  <= (in_func == FUNC_ADD || in_func == FUNC_CLEAR) ? S_FIN : S_SRCH;
          end
        end
        S_SRCH: begin
          if (hit) begin
            found_r <= 1'b1;
            state_r <= (func_r == FUNC_DEL) ? S_SHIFT : S_FIN;
          end else if (!rd_en && !rd_vld_r) begin
            state_r <= S_FIN;
          end
        end
        S_SHIFT: begin
          if (!rd_en && !rd_vld_r) state_r <= S_FIN;
        end
        S_FIN: begin
          state_r           <= S_IDLE;
          total_r           <= total_nxt;
          rej_r             <= fails_nxt;
          out_status        <= status_nxt;
          out_entry_count   <= 7'(total_nxt);
          out_failure_count <= fails_nxt;
          if (take_last) begin
            last_r      <= uid_r;
            last_time_r <= now_r;
          end
          if (grant) cool_end_r <= now_r + cooldown_r;
          if (lock_start) lock_end_r <= now_r + lockout_r;
          if (take_last && !found_r && win_restart) win_start_r <= now_r;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Table never overflows its capacity.
  assert property (@(posedge clk) disable iff (!rst_n) total_r <= CNT_W'(ENTRIES))
    else $error("entry total above capacity");
  // A result is only shown as the command finishes.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> $past(state_r) == S_FIN)
    else $error("result without finishing command");
  // Shift writes land strictly below total.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && rd_vld_r) |-> rd_idx_r < total_r)
    else $error("shift out of range");

endmodule
`default_nettype wire
